FILE: src/tjapl_pkg.sv
// Shared types, constants and helpers for the two-joint arm power limiter.
package tjapl_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int POWER_BITS = 16;
  localparam int PX_BITS    = POWER_BITS + 2;
  localparam int REG_BITS   = 48;
  localparam int SLOT_BITS  = 16;
  localparam int IDX_BITS   = 3;

  localparam logic [IDX_BITS-1:0] REG_SHOULDER_POWER = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_ELBOW_POWER    = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_SHOULDER_NEG   = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_SHOULDER_POS   = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_ELBOW_NEG      = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_ELBOW_POS      = 3'd5;

  localparam logic [2:0] ZONE_NONE     = 3'd0;
  localparam logic [2:0] ZONE_NEG_STOP = 3'd1;
  localparam logic [2:0] ZONE_POS_STOP = 3'd4;

  localparam logic [1:0] LVL_STOP = 2'd0;
  localparam logic [1:0] LVL_PARK = 2'd1;
  localparam logic [1:0] LVL_SLOW = 2'd2;

  localparam logic signed [ANGLE_BITS-1:0] ANGLE_M90  = -(ANGLE_BITS'(1) << (ANGLE_BITS - 2));
  localparam logic signed [ANGLE_BITS-1:0] ANGLE_ZERO = '0;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] shoulder_angle;
    logic signed [ANGLE_BITS-1:0] elbow_angle;
    logic                         sensors_valid;
    logic signed [POWER_BITS-1:0] shoulder_request;
    logic signed [POWER_BITS-1:0] elbow_request;
  } sample_t;

  typedef struct packed {
    logic signed [POWER_BITS-1:0] shoulder_drive;
    logic signed [POWER_BITS-1:0] elbow_drive;
    logic                         status_ok;
    logic [2:0]                   shoulder_zone;
    logic [2:0]                   elbow_zone;
    logic                         shoulder_coupled;
  } drive_t;

  typedef struct packed {
    logic [2:0]                code;
    logic [1:0]                level;
    logic signed [PX_BITS-1:0] power;
  } zone_res_t;

  function automatic logic [SLOT_BITS-1:0] slot(input logic [REG_BITS-1:0] r,
                                                input int unsigned i);
    return r[SLOT_BITS*i +: SLOT_BITS];
  endfunction

  // Magnitude slot, masked to the power width, as a non-negative wide value.
  function automatic logic signed [PX_BITS-1:0] mag(input logic [REG_BITS-1:0] r,
                                                    input int unsigned i);
    logic [POWER_BITS-1:0] m;
    m = POWER_BITS'(slot(r, i));
    return $signed({2'b00, m});
  endfunction

  function automatic logic signed [ANGLE_BITS-1:0] ang(input logic [REG_BITS-1:0] r,
                                                       input int unsigned i);
    return $signed(ANGLE_BITS'(slot(r, i)));
  endfunction

endpackage

FILE: src/tjapl_zone.sv
// Zone check and power cap for one joint.
module tjapl_zone import tjapl_pkg::*; (
  input  logic signed [PX_BITS-1:0]    power,
  input  logic signed [ANGLE_BITS-1:0] angle,
  input  logic signed [ANGLE_BITS-1:0] bound,
  input  logic [REG_BITS-1:0]          power_limits,
  input  logic [REG_BITS-1:0]          neg_limits,
  input  logic [REG_BITS-1:0]          pos_limits,
  output zone_res_t                    res
);

  always_comb begin
    logic signed [PX_BITS-1:0] m;
    logic hit;
    hit = 1'b0;
    res.code  = ZONE_NONE;
    res.level = LVL_STOP;
    res.power = power;
    for (int unsigned i = 0; i < 3; i++) begin
      m = (i == 0) ? '0 : mag(power_limits, i);
      if (!hit && power < -m && bound <= angle && angle < ang(neg_limits, i)) begin
        hit = 1'b1;
        res.power = -m;
        res.level = 2'(i);
        res.code  = ZONE_NEG_STOP + 3'(i);
      end
    end
    for (int unsigned i = 0; i < 3; i++) begin
      m = (i == 0) ? '0 : mag(power_limits, i);
      if (!hit && power > m && ang(pos_limits, i) <= angle && angle < bound) begin
        hit = 1'b1;
        res.power = m;
        res.level = 2'(i);
        res.code  = ZONE_POS_STOP + 3'(i);
      end
    end
  end

endmodule

FILE: src/two_joint_arm_power_limiter_unit.sv
// Top level of the two-joint arm power limiter: registers, handshake and coupling.
// Path: a sample item is held in the input register, then its drive item in the result register,
//   with compare and clamp between them.
// Throughput: one item per cycle; while a finished drive item waits on a stalled output,
//   the input register takes one more item and then holds.
// Reset: synchronous rst empties both stages and clears all six limit registers to 0.
module two_joint_arm_power_limiter_unit import tjapl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  sample_t             sample,
  output logic                drive_valid,
  input  logic                drive_ready,
  output drive_t              drive,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0] cfg_data
);

  logic [REG_BITS-1:0] shoulder_power_limits;
  logic [REG_BITS-1:0] elbow_power_limits;
  logic [REG_BITS-1:0] shoulder_negative_limits;
  logic [REG_BITS-1:0] shoulder_positive_limits;
  logic [REG_BITS-1:0] elbow_negative_limits;
  logic [REG_BITS-1:0] elbow_positive_limits;

  logic    held_valid;
  sample_t held;
  logic    advance;
  drive_t  drive_next;

  logic signed [PX_BITS-1:0] sp_clamped;
  logic signed [PX_BITS-1:0] ep_clamped;
  zone_res_t                 sres;
  zone_res_t                 eres;

  assign cfg_ready    = 1'b1;
  assign advance      = !drive_valid || drive_ready;
  assign sample_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      shoulder_power_limits    <= '0;
      elbow_power_limits       <= '0;
      shoulder_negative_limits <= '0;
      shoulder_positive_limits <= '0;
      elbow_negative_limits    <= '0;
      elbow_positive_limits    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SHOULDER_POWER: shoulder_power_limits    <= cfg_data;
        REG_ELBOW_POWER:    elbow_power_limits       <= cfg_data;
        REG_SHOULDER_NEG:   shoulder_negative_limits <= cfg_data;
        REG_SHOULDER_POS:   shoulder_positive_limits <= cfg_data;
        REG_ELBOW_NEG:      elbow_negative_limits    <= cfg_data;
        REG_ELBOW_POS:      elbow_positive_limits    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (sample_valid && sample_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
    if (sample_valid && sample_ready) begin
      held <= sample;
    end
  end

  function automatic logic signed [PX_BITS-1:0] clamp_mag(
    input logic signed [PX_BITS-1:0] p,
    input logic signed [PX_BITS-1:0] m
  );
    logic signed [PX_BITS-1:0] r;
    r = p;
    if (r > m) r = m;
    if (r < -m) r = -m;
    return r;
  endfunction

  function automatic logic signed [POWER_BITS-1:0] saturate(
    input logic signed [PX_BITS-1:0] p
  );
    logic signed [PX_BITS-1:0] pmax;
    logic signed [PX_BITS-1:0] pmin;
    pmax = $signed({3'b000, {(POWER_BITS-1){1'b1}}});
    pmin = $signed({3'b111, {(POWER_BITS-1){1'b0}}});
    if (p > pmax) return pmax[POWER_BITS-1:0];
    if (p < pmin) return pmin[POWER_BITS-1:0];
    return p[POWER_BITS-1:0];
  endfunction

  assign sp_clamped = clamp_mag(PX_BITS'(held.shoulder_request), mag(shoulder_power_limits, 0));
  assign ep_clamped = clamp_mag(PX_BITS'(held.elbow_request), mag(elbow_power_limits, 0));

  tjapl_zone u_shoulder_zone (
    .power        (sp_clamped),
    .angle        (held.shoulder_angle),
    .bound        (ANGLE_M90),
    .power_limits (shoulder_power_limits),
    .neg_limits   (shoulder_negative_limits),
    .pos_limits   (shoulder_positive_limits),
    .res          (sres)
  );

  tjapl_zone u_elbow_zone (
    .power        (ep_clamped),
    .angle        (held.elbow_angle),
    .bound        (ANGLE_ZERO),
    .power_limits (elbow_power_limits),
    .neg_limits   (elbow_negative_limits),
    .pos_limits   (elbow_positive_limits),
    .res          (eres)
  );

  always_comb begin
    logic signed [PX_BITS-1:0] m;
    logic signed [PX_BITS-1:0] sp;
    logic                      coupled;
    sp      = sres.power;
    coupled = 1'b0;
    case (eres.level)
      LVL_PARK: m = mag(shoulder_power_limits, 1);
      LVL_SLOW: m = mag(shoulder_power_limits, 2);
      default:  m = '0;
    endcase
    if (eres.code != ZONE_NONE) begin
      if (eres.code < ZONE_POS_STOP && sp < -m) begin
        sp      = -m;
        coupled = 1'b1;
      end
      if (eres.code >= ZONE_POS_STOP && sp > m) begin
        sp      = m;
        coupled = 1'b1;
      end
    end
    drive_next = '0;
    if (held.sensors_valid) begin
      drive_next.shoulder_drive   = saturate(sp);
      drive_next.elbow_drive      = saturate(eres.power);
      drive_next.status_ok        = 1'b1;
      drive_next.shoulder_zone    = sres.code;
      drive_next.elbow_zone       = eres.code;
      drive_next.shoulder_coupled = coupled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (advance) begin
      drive_valid <= held_valid;
    end
    if (advance && held_valid) begin
      drive <= drive_next;
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    drive_valid && !drive.status_ok |->
      drive.shoulder_drive == '0 && drive.elbow_drive == '0 &&
      drive.shoulder_zone == ZONE_NONE && drive.elbow_zone == ZONE_NONE &&
      !drive.shoulder_coupled)
    else $error("drive item not zeroed for invalid sensors");

  a_coupled_needs_elbow: assert property (@(posedge clk) disable iff (rst)
    drive_valid && drive.shoulder_coupled |-> drive.elbow_zone != ZONE_NONE)
    else $error("shoulder coupled without an elbow zone");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !held_valid |-> sample_ready)
    else $error("empty input register refused an item");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    held_valid && advance |=> drive_valid)
    else $error("held item did not reach the output");

endmodule

FILE: tb/sv/two_joint_arm_power_limiter_checker.sv
// Checker for the arm power limiter: predicts each drive item and compares it.
`timescale 1ns / 1ps

module two_joint_arm_power_limiter_checker import tjapl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  input  logic                sample_ready,
  input  sample_t             sample,
  input  logic                drive_valid,
  input  logic                drive_ready,
  input  drive_t              drive,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0] cfg_data,
  output int                  error_count,
  output int                  pending_count
);

  logic [REG_BITS-1:0] limit_reg [6];
  drive_t              drive_exp_q [$];
  drive_t              exp_drive;

  function automatic int power_limit(input int r, input int i);
    logic [POWER_BITS-1:0] m;
    m = POWER_BITS'(limit_reg[r][SLOT_BITS*i +: SLOT_BITS]);
    return int'(m);
  endfunction

  function automatic int angle_limit(input int r, input int i);
    logic signed [ANGLE_BITS-1:0] a;
    a = ANGLE_BITS'(limit_reg[r][SLOT_BITS*i +: SLOT_BITS]);
    return int'(a);
  endfunction

  function automatic int clamp_power(input int p, input int m);
    if (p > m) p = m;
    if (p < -m) p = -m;
    return p;
  endfunction

  function automatic logic [POWER_BITS-1:0] saturate_power(input int p);
    int pmax;
    pmax = (1 << (POWER_BITS - 1)) - 1;
    if (p > pmax) p = pmax;
    if (p < -pmax - 1) p = -pmax - 1;
    return POWER_BITS'(p);
  endfunction

  // Negative zone is bound <= a < limit, positive zone is limit <= a < bound.
  function automatic logic [2:0] limit_zone(inout int p, input int a, input int bound,
                                            input int preg, input int nreg,
                                            input int posreg, inout int lvl);
    int m;
    int v;
    v = p;
    for (int i = 0; i < 3; i++) begin
      m = (i == LVL_STOP) ? 0 : power_limit(preg, i);
      if (v < -m && bound <= a && a < angle_limit(nreg, i)) begin
        p = -m;
        lvl = i;
        return ZONE_NEG_STOP + 3'(i);
      end
    end
    for (int i = 0; i < 3; i++) begin
      m = (i == LVL_STOP) ? 0 : power_limit(preg, i);
      if (v > m && angle_limit(posreg, i) <= a && a < bound) begin
        p = m;
        lvl = i;
        return ZONE_POS_STOP + 3'(i);
      end
    end
    return ZONE_NONE;
  endfunction

  function automatic drive_t predict_drive(input sample_t s);
    drive_t     d;
    int         sp;
    int         ep;
    int         lvl;
    int         m;
    logic [2:0] sz;
    logic [2:0] ez;
    d = '0;
    if (!s.sensors_valid) return d;
    sp = clamp_power(int'($signed(s.shoulder_request)), power_limit(REG_SHOULDER_POWER, 0));
    ep = clamp_power(int'($signed(s.elbow_request)), power_limit(REG_ELBOW_POWER, 0));
    lvl = LVL_STOP;
    sz = limit_zone(sp, int'($signed(s.shoulder_angle)), int'(ANGLE_M90),
                    REG_SHOULDER_POWER, REG_SHOULDER_NEG, REG_SHOULDER_POS, lvl);
    ez = limit_zone(ep, int'($signed(s.elbow_angle)), int'(ANGLE_ZERO),
                    REG_ELBOW_POWER, REG_ELBOW_NEG, REG_ELBOW_POS, lvl);
    if (ez != ZONE_NONE) begin
      m = (lvl == LVL_STOP) ? 0 : power_limit(REG_SHOULDER_POWER, lvl);
      if (ez < ZONE_POS_STOP && sp < -m) begin
        sp = -m;
        d.shoulder_coupled = 1'b1;
      end
      if (ez >= ZONE_POS_STOP && sp > m) begin
        sp = m;
        d.shoulder_coupled = 1'b1;
      end
    end
    d.shoulder_drive = saturate_power(sp);
    d.elbow_drive    = saturate_power(ep);
    d.status_ok      = 1'b1;
    d.shoulder_zone  = sz;
    d.elbow_zone     = ez;
    return d;
  endfunction

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      drive_exp_q.delete();
      for (int r = 0; r < 6; r++) limit_reg[r] = '0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= REG_ELBOW_POS) begin
        limit_reg[cfg_index] = cfg_data;
      end
      if (drive_valid && drive_ready) begin
        if (drive_exp_q.size() == 0) begin
          if (error_count < 10) begin
            $display("%0t: drive item with no sample pending: drv %0d/%0d ok %0b zone %0d/%0d cpl %0b",
                     $time, drive.shoulder_drive, drive.elbow_drive, drive.status_ok,
                     drive.shoulder_zone, drive.elbow_zone, drive.shoulder_coupled);
          end
          error_count++;
        end else begin
          exp_drive = drive_exp_q.pop_front();
          if (drive.shoulder_drive !== exp_drive.shoulder_drive ||
              drive.elbow_drive !== exp_drive.elbow_drive ||
              drive.status_ok !== exp_drive.status_ok ||
              drive.shoulder_zone !== exp_drive.shoulder_zone ||
              drive.elbow_zone !== exp_drive.elbow_zone ||
              drive.shoulder_coupled !== exp_drive.shoulder_coupled) begin
            if (error_count < 10) begin
              $display("%0t: drive mismatch: exp drv %0d/%0d ok %0b zone %0d/%0d cpl %0b",
                       $time, exp_drive.shoulder_drive, exp_drive.elbow_drive,
                       exp_drive.status_ok, exp_drive.shoulder_zone, exp_drive.elbow_zone,
                       exp_drive.shoulder_coupled);
              $display("%0t:                 got drv %0d/%0d ok %0b zone %0d/%0d cpl %0b",
                       $time, drive.shoulder_drive, drive.elbow_drive, drive.status_ok,
                       drive.shoulder_zone, drive.elbow_zone, drive.shoulder_coupled);
            end
            error_count++;
          end
        end
      end
      if (sample_valid && sample_ready) drive_exp_q.push_back(predict_drive(sample));
    end
    pending_count = drive_exp_q.size();
  end

endmodule

FILE: tb/sv/two_joint_arm_power_limiter_unit_test.sv
// Testbench top for the arm power limiter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module two_joint_arm_power_limiter_unit_test import tjapl_pkg::*;;

  localparam logic [IDX_BITS-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_UNUSED_HI = 3'd7;

  localparam int LIM_ZONED = 0;
  localparam int LIM_RAW   = 1;
  localparam int LIM_ONES  = 2;
  localparam int LIM_BRINK = 3;

  logic                clk;
  logic                rst;
  logic                sample_valid;
  logic                sample_ready;
  sample_t             sample;
  logic                drive_valid;
  logic                drive_ready;
  drive_t              drive;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_BITS-1:0] cfg_index;
  logic [REG_BITS-1:0] cfg_data;

  int                  error_count;
  int                  pending_count;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  logic [REG_BITS-1:0] limit_word [6];

  two_joint_arm_power_limiter_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .drive_valid  (drive_valid),
    .drive_ready  (drive_ready),
    .drive        (drive),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  two_joint_arm_power_limiter_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .sample        (sample),
    .drive_valid   (drive_valid),
    .drive_ready   (drive_ready),
    .drive         (drive),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    drive_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic logic [REG_BITS-1:0] pack3(input int s0, input int s1, input int s2);
    return {SLOT_BITS'(s2), SLOT_BITS'(s1), SLOT_BITS'(s0)};
  endfunction

  function automatic sample_t make_sample(input int sa, input int ea, input bit ok,
                                          input int sr, input int er);
    sample_t s;
    s.shoulder_angle   = ANGLE_BITS'(sa);
    s.elbow_angle      = ANGLE_BITS'(ea);
    s.sensors_valid    = ok;
    s.shoulder_request = POWER_BITS'(sr);
    s.elbow_request    = POWER_BITS'(er);
    return s;
  endfunction

  function automatic logic [REG_BITS-1:0] power_limits(input bit brink);
    int pmax;
    pmax = brink ? 'hFFFF : int'($urandom_range(16000, 32767));
    if (brink) return pack3(pmax, int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)));
    return pack3(pmax, int'($urandom_range(0, 6000)), int'($urandom_range(4000, 16000)));
  endfunction

  // dir is +1 for a zone above its bound, -1 for one below it.
  function automatic logic [REG_BITS-1:0] zone_limits(input int bound, input int dir,
                                                      input bit brink);
    int stop_a;
    int park_a;
    int slow_a;
    stop_a = brink ? bound : bound + dir * int'($urandom_range(0, 6000));
    park_a = stop_a + dir * int'($urandom_range(0, 5000));
    slow_a = park_a + dir * int'($urandom_range(0, 5000));
    if (brink) slow_a = (dir > 0) ? 32767 : -32768;
    return pack3(stop_a, park_a, slow_a);
  endfunction

  function automatic int near_limit(input logic [IDX_BITS-1:0] r);
    int k;
    k = int'($urandom_range(0, 2));
    return int'($signed(limit_word[r][SLOT_BITS*k +: SLOT_BITS])) +
           int'($urandom_range(0, 6)) - 3;
  endfunction

  function automatic int rand_power();
    case ($urandom_range(0, 3))
      0: return int'($urandom);
      1: return $urandom_range(0, 1) ? 32767 : -32768;
      2: return int'($urandom_range(0, 4)) - 2;
      default: return int'($urandom_range(0, 40000)) - 20000;
    endcase
  endfunction

  function automatic sample_t rand_sample();
    int sa;
    int ea;
    case ($urandom_range(0, 3))
      0: sa = int'($urandom);
      1: sa = int'(ANGLE_M90) + int'($urandom_range(0, 400)) - 200;
      2: sa = -int'($urandom_range(0, 32768));
      default: sa = near_limit($urandom_range(0, 1) ? REG_SHOULDER_NEG : REG_SHOULDER_POS);
    endcase
    case ($urandom_range(0, 3))
      0: ea = int'($urandom);
      1: ea = int'($urandom_range(0, 400)) - 200;
      2: ea = int'($urandom_range(0, 20000)) - 10000;
      default: ea = near_limit($urandom_range(0, 1) ? REG_ELBOW_NEG : REG_ELBOW_POS);
    endcase
    return make_sample(sa, ea, $urandom_range(0, 9) != 0, rand_power(), rand_power());
  endfunction

  task automatic send_sample(input sample_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_ELBOW_POS) limit_word[idx] = data;
  endtask

  task automatic program_limits(input int kind);
    logic [REG_BITS-1:0] w [6];
    bit                  brink;
    brink = (kind == LIM_BRINK);
    w[REG_SHOULDER_POWER] = power_limits(brink);
    w[REG_ELBOW_POWER]    = power_limits(brink);
    w[REG_SHOULDER_NEG]   = zone_limits(int'(ANGLE_M90), 1, brink);
    w[REG_SHOULDER_POS]   = zone_limits(int'(ANGLE_M90), -1, brink);
    w[REG_ELBOW_NEG]      = zone_limits(int'(ANGLE_ZERO), 1, brink);
    w[REG_ELBOW_POS]      = zone_limits(int'(ANGLE_ZERO), -1, brink);
    for (int r = 0; r < 6; r++) begin
      if (kind == LIM_RAW) w[r] = REG_BITS'({$urandom, $urandom});
      if (kind == LIM_ONES) w[r] = '1;
      write_limit(IDX_BITS'(r), w[r]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst           = 1'b1;
    sample_valid  = 1'b0;
    sample        = '0;
    drive_ready   = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 25;
    recv_idle_pct = 75;
    for (int r = 0; r < 6; r++) limit_word[r] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_sample(make_sample(-16384, 0, 1, 32767, -32768));
    send_sample(make_sample(0, 0, 0, -1, -1));
    wait_idle();

    write_limit(REG_SHOULDER_POWER, pack3(24000, 3000, 10000));
    write_limit(REG_ELBOW_POWER, pack3(20000, 2000, 8000));
    write_limit(REG_SHOULDER_NEG, pack3(-12000, -8000, -4000));
    write_limit(REG_SHOULDER_POS, pack3(-20000, -24000, -28000));
    write_limit(REG_ELBOW_NEG, pack3(2000, 5000, 9000));
    write_limit(REG_ELBOW_POS, pack3(-2000, -5000, -9000));
    write_limit(REG_UNUSED_LO, '1);
    write_limit(REG_UNUSED_HI, '1);
    cfg_valid <= 1'b0;

    send_sample(make_sample(8000, 20000, 0, 32767, -32768));
    send_sample(make_sample(-16384, 20000, 1, -5000, 0));
    send_sample(make_sample(-10000, 20000, 1, -5000, 0));
    send_sample(make_sample(-6000, 20000, 1, -20000, 0));
    send_sample(make_sample(-18000, 20000, 1, 5000, 0));
    send_sample(make_sample(-22000, 20000, 1, 5000, 0));
    send_sample(make_sample(-26000, 20000, 1, 20000, 0));
    send_sample(make_sample(8000, 20000, 1, 32767, 32767));
    send_sample(make_sample(8000, 20000, 1, -32768, -32768));
    send_sample(make_sample(8000, 1000, 1, -500, -100));
    send_sample(make_sample(8000, 3000, 1, -20000, -5000));
    send_sample(make_sample(8000, 7000, 1, -5000, -15000));
    send_sample(make_sample(8000, -1000, 1, 100, 100));
    send_sample(make_sample(8000, -3000, 1, 32767, 5000));
    send_sample(make_sample(8000, -7000, 1, 15000, 15000));
    send_sample(make_sample(-16384, 0, 1, -1, -1));
    send_sample(make_sample(-32768, -32768, 1, 1, -1));
    send_sample(make_sample(32767, 32767, 1, -1, 1));
    wait_idle();

    program_limits(LIM_ONES);
    send_sample(make_sample(0, 0, 1, -32768, 32767));
    send_sample(make_sample(-100, -1, 1, 32767, -32768));
    send_sample(make_sample(-1, -1, 1, -1, 1));

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 75 : 0;
      recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 25 : 0;
      for (int kind = LIM_ZONED; kind <= LIM_BRINK; kind++) begin
        wait_idle();
        program_limits(kind);
        repeat (140) send_sample(rand_sample());
      end
    end

    wait_idle();
    @(negedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
